/* rtl/core/ut2cal_pkg.sv */
// ----------------------------------------------------------------------------
// ut2cal_pkg
// Shared types, constants and tables for the epoch-seconds to calendar block.
// ----------------------------------------------------------------------------
package ut2cal_pkg;

    localparam logic [31:0] SEC_PER_DAY  = 32'd86400;
    localparam logic [31:0] SEC_PER_HOUR = 32'd3600;
    localparam logic [31:0] SEC_PER_MIN  = 32'd60;

    localparam logic [11:0] EPOCH_YEAR     = 12'd1970;
    localparam logic [1:0]  EPOCH_MOD4     = 2'd2;
    localparam logic [6:0]  EPOCH_MOD100   = 7'd70;
    localparam logic [8:0]  EPOCH_MOD400   = 9'd370;
    localparam logic [6:0]  MOD100_LAST    = 7'd99;
    localparam logic [8:0]  MOD400_LAST    = 9'd399;

    localparam logic [15:0] DAYS_COMMON    = 16'd365;
    localparam logic [15:0] DAYS_LEAP      = 16'd366;

    localparam logic [3:0]  MONTH_JAN      = 4'd0;
    localparam logic [3:0]  MONTH_FEB      = 4'd1;
    localparam logic [3:0]  MONTH_DEC      = 4'd11;

    // divide phases: a quotient step, then the remainder step that follows it
    localparam logic [2:0]  PH_DAY      = 3'd0;
    localparam logic [2:0]  PH_DAY_REM  = 3'd1;
    localparam logic [2:0]  PH_HOUR     = 3'd2;
    localparam logic [2:0]  PH_HOUR_REM = 3'd3;
    localparam logic [2:0]  PH_MIN      = 3'd4;
    localparam logic [2:0]  PH_MIN_REM  = 3'd5;

    // reciprocals of the odd parts: 675 (scaled by 2^35), 225 (2^21), 15 (2^14)
    localparam logic [25:0] RECIP_DAY  = 26'd50903317;
    localparam logic [13:0] RECIP_HOUR = 14'd9321;
    localparam logic [10:0] RECIP_MIN  = 11'd1093;

    typedef struct packed {
        logic       load;
        logic       div_step;
        logic [2:0] phase;
        logic       year_step;
        logic       month_step;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic year_fits;
        logic month_fits;
    } sts_t;

    function automatic logic [4:0] month_len(input logic [3:0] month,
                                             input logic leap);
        logic [4:0] len;
        case (month)
            4'd0:    len = 5'd31;
            4'd1:    len = leap ? 5'd29 : 5'd28;
            4'd2:    len = 5'd31;
            4'd3:    len = 5'd30;
            4'd4:    len = 5'd31;
            4'd5:    len = 5'd30;
            4'd6:    len = 5'd31;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd30;
            4'd9:    len = 5'd31;
            4'd10:   len = 5'd30;
            4'd11:   len = 5'd31;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

/* rtl/core/ut2cal_dp.sv */
// ----------------------------------------------------------------------------
// ut2cal_dp
// Datapath: reciprocal-multiply divide steps, year and month walkers and the
// result register.
// ----------------------------------------------------------------------------
module ut2cal_dp (
    input  logic              aclk,
    input  logic [31:0]       s_unix_seconds,
    input  ut2cal_pkg::cmd_t  cmd,
    output ut2cal_pkg::sts_t  sts,
    output logic [4:0]        m_day_of_month,
    output logic [3:0]        m_month_number,
    output logic [11:0]       m_year,
    output logic [4:0]        m_hour,
    output logic [5:0]        m_minute,
    output logic [5:0]        m_second_of_minute
);
    import ut2cal_pkg::*;

    logic [31:0] rem_reg, rem_next;
    logic [15:0] days_reg, days_next;
    logic [4:0]  hour_reg, hour_next;
    logic [5:0]  minute_reg, minute_next;
    logic [11:0] year_reg, year_next;
    logic [1:0]  mod4_reg, mod4_next;
    logic [6:0]  mod100_reg, mod100_next;
    logic [8:0]  mod400_reg, mod400_next;
    logic [3:0]  month_reg, month_next;

    logic [4:0]  out_day_reg, out_day_next;
    logic [3:0]  out_month_reg, out_month_next;
    logic [11:0] out_year_reg, out_year_next;
    logic [4:0]  out_hour_reg, out_hour_next;
    logic [5:0]  out_minute_reg, out_minute_next;
    logic [5:0]  out_second_reg, out_second_next;

    logic [50:0] day_prod;
    logic [32:0] day_secs;
    logic [26:0] hour_prod;
    logic [16:0] hour_secs;
    logic [20:0] min_prod;
    logic [11:0] min_secs;
    logic        leap;
    logic [15:0] ylen;
    logic [15:0] mlen;

    // 86400 = 128 * 675, 3600 = 16 * 225, 60 = 4 * 15
    assign day_prod  = rem_reg[31:7] * RECIP_DAY;
    assign day_secs  = days_reg * SEC_PER_DAY[16:0];
    assign hour_prod = rem_reg[16:4] * RECIP_HOUR;
    assign hour_secs = hour_reg * SEC_PER_HOUR[11:0];
    assign min_prod  = rem_reg[11:2] * RECIP_MIN;
    assign min_secs  = minute_reg * SEC_PER_MIN[5:0];

    assign leap = (mod400_reg == 9'd0) || ((mod4_reg == 2'd0) && (mod100_reg != 7'd0));
    assign ylen = leap ? DAYS_LEAP : DAYS_COMMON;
    assign mlen = {11'd0, month_len(month_reg, leap)};

    assign sts.year_fits  = days_reg < ylen;
    assign sts.month_fits = (month_reg == MONTH_DEC) || (days_reg < mlen);

    always_comb begin
        rem_next        = rem_reg;
        days_next       = days_reg;
        hour_next       = hour_reg;
        minute_next     = minute_reg;
        year_next       = year_reg;
        mod4_next       = mod4_reg;
        mod100_next     = mod100_reg;
        mod400_next     = mod400_reg;
        month_next      = month_reg;
        out_day_next    = out_day_reg;
        out_month_next  = out_month_reg;
        out_year_next   = out_year_reg;
        out_hour_next   = out_hour_reg;
        out_minute_next = out_minute_reg;
        out_second_next = out_second_reg;

        if (cmd.load) begin
            rem_next    = s_unix_seconds;
            year_next   = EPOCH_YEAR;
            mod4_next   = EPOCH_MOD4;
            mod100_next = EPOCH_MOD100;
            mod400_next = EPOCH_MOD400;
            month_next  = MONTH_JAN;
        end

        if (cmd.div_step) begin
            case (cmd.phase)
                PH_DAY:      days_next   = day_prod[50:35];
                PH_DAY_REM:  rem_next    = rem_reg - day_secs[31:0];
                PH_HOUR:     hour_next   = hour_prod[25:21];
                PH_HOUR_REM: rem_next    = rem_reg - {15'd0, hour_secs};
                PH_MIN:      minute_next = min_prod[19:14];
                PH_MIN_REM:  rem_next    = rem_reg - {20'd0, min_secs};
                default:     rem_next    = rem_reg;
            endcase
        end

        if (cmd.year_step) begin
            days_next   = days_reg - ylen;
            year_next   = year_reg + 12'd1;
            mod4_next   = mod4_reg + 2'd1;
            mod100_next = (mod100_reg == MOD100_LAST) ? 7'd0 : mod100_reg + 7'd1;
            mod400_next = (mod400_reg == MOD400_LAST) ? 9'd0 : mod400_reg + 9'd1;
        end

        if (cmd.month_step) begin
            days_next  = days_reg - mlen;
            month_next = month_reg + 4'd1;
        end

        if (cmd.out_load) begin
            out_day_next    = days_reg[4:0] + 5'd1;
            out_month_next  = month_reg + 4'd1;
            out_year_next   = year_reg;
            out_hour_next   = hour_reg;
            out_minute_next = minute_reg;
            // what is left after the minute step is the second
            out_second_next = rem_reg[5:0];
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg        <= rem_next;
        days_reg       <= days_next;
        hour_reg       <= hour_next;
        minute_reg     <= minute_next;
        year_reg       <= year_next;
        mod4_reg       <= mod4_next;
        mod100_reg     <= mod100_next;
        mod400_reg     <= mod400_next;
        month_reg      <= month_next;
        out_day_reg    <= out_day_next;
        out_month_reg  <= out_month_next;
        out_year_reg   <= out_year_next;
        out_hour_reg   <= out_hour_next;
        out_minute_reg <= out_minute_next;
        out_second_reg <= out_second_next;
    end

    assign m_day_of_month     = out_day_reg;
    assign m_month_number     = out_month_reg;
    assign m_year             = out_year_reg;
    assign m_hour             = out_hour_reg;
    assign m_minute           = out_minute_reg;
    assign m_second_of_minute = out_second_reg;

endmodule

/* rtl/core/ut2cal_ctrl.sv */
// ----------------------------------------------------------------------------
// ut2cal_ctrl
// Controller: sequences the divide phases, the year and month walks and the
// handoff into the result register.
// ----------------------------------------------------------------------------
module ut2cal_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output ut2cal_pkg::cmd_t  cmd,
    input  ut2cal_pkg::sts_t  sts
);
    import ut2cal_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DIV    = 3'd1;
    localparam logic [2:0] ST_YEAR   = 3'd2;
    localparam logic [2:0] ST_MONTH  = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [2:0] phase_reg, phase_next;
    logic       m_valid_reg, m_valid_next;

    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        cmd            = '0;
        cmd.phase      = phase_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    phase_next = PH_DAY;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (phase_reg == PH_MIN_REM) begin
                    state_next = ST_YEAR;
                end else begin
                    phase_next = phase_reg + 3'd1;
                end
            end
            ST_YEAR: begin
                if (sts.year_fits) begin
                    state_next = ST_MONTH;
                end else begin
                    cmd.year_step = 1'b1;
                end
            end
            ST_MONTH: begin
                if (sts.month_fits) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.month_step = 1'b1;
                end
            end
            ST_FINISH: begin
                // wait only while the previous result is still unclaimed
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_DAY;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

/* rtl/core/unix_time_to_calendar.sv */
// ----------------------------------------------------------------------------
// unix_time_to_calendar
// Steps: 6 divide steps (quotient, then remainder, for day, hour, minute),
// one step per year past 1970 and per month past January, then the
// close of both walks and the result load. One request at a time; the next is
// taken while a result waits, and its result stalls until that one is claimed.
// Reset: synchronous active-low aresetn clears the controller and m_valid.
// ----------------------------------------------------------------------------
module unix_time_to_calendar (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_unix_seconds,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [4:0]  m_day_of_month,
    output logic [3:0]  m_month_number,
    output logic [11:0] m_year,
    output logic [4:0]  m_hour,
    output logic [5:0]  m_minute,
    output logic [5:0]  m_second_of_minute
);
    import ut2cal_pkg::*;

    cmd_t cmd;
    sts_t sts;

    ut2cal_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    ut2cal_dp u_dp (
        .aclk               (aclk),
        .s_unix_seconds     (s_unix_seconds),
        .cmd                (cmd),
        .sts                (sts),
        .m_day_of_month     (m_day_of_month),
        .m_month_number     (m_month_number),
        .m_year             (m_year),
        .m_hour             (m_hour),
        .m_minute           (m_minute),
        .m_second_of_minute (m_second_of_minute)
    );

endmodule

/* test/calendar_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// calendar_checker
// Watches both channels of the epoch-seconds to calendar converter, works out
// the date and time of every accepted request and compares each result with
// the oldest conversion still owed.
// ----------------------------------------------------------------------------
module calendar_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [31:0] s_unix_seconds,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [4:0]  m_day_of_month,
    input  logic [3:0]  m_month_number,
    input  logic [11:0] m_year,
    input  logic [4:0]  m_hour,
    input  logic [5:0]  m_minute,
    input  logic [5:0]  m_second_of_minute,
    output int          mismatches,
    output int          outstanding,
    output int          conversions
);

    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } calendar_t;

    calendar_t owed_dates[$];

    function automatic bit leap_year(input int unsigned y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic calendar_t to_calendar(input logic [31:0] secs);
        int unsigned month_days[12];
        int unsigned days;
        int unsigned tod;
        int unsigned yr;
        int unsigned mon;
        int unsigned span;
        calendar_t   c;
        month_days = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        days = secs / ut2cal_pkg::SEC_PER_DAY;
        tod  = secs % ut2cal_pkg::SEC_PER_DAY;
        yr   = 32'(ut2cal_pkg::EPOCH_YEAR);
        mon  = 0;
        while (1) begin
            span = leap_year(yr) ? 366 : 365;
            if (days < span)
                break;
            days -= span;
            yr++;
        end
        while (mon < 11) begin
            span = month_days[mon];
            if (mon == 1 && leap_year(yr))
                span = 29;
            if (days < span)
                break;
            days -= span;
            mon++;
        end
        c.day    = 5'(days + 1);
        c.month  = 4'(mon + 1);
        c.year   = 12'(yr);
        c.hour   = 5'(tod / ut2cal_pkg::SEC_PER_HOUR);
        c.minute = 6'((tod % ut2cal_pkg::SEC_PER_HOUR) / ut2cal_pkg::SEC_PER_MIN);
        c.second = 6'(tod % ut2cal_pkg::SEC_PER_MIN);
        return c;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : watch
        calendar_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (owed_dates.size() == 0) begin
                    $error("result with no request pending");
                    mismatches++;
                end else begin
                    want = owed_dates.pop_front();
                    check_field("day_of_month", 32'(want.day), 32'(m_day_of_month));
                    check_field("month_number", 32'(want.month), 32'(m_month_number));
                    check_field("year", 32'(want.year), 32'(m_year));
                    check_field("hour", 32'(want.hour), 32'(m_hour));
                    check_field("minute", 32'(want.minute), 32'(m_minute));
                    check_field("second_of_minute", 32'(want.second),
                                32'(m_second_of_minute));
                    conversions++;
                end
            end
            if (s_valid && s_ready)
                owed_dates.push_back(to_calendar(s_unix_seconds));
        end
        outstanding = owed_dates.size();
    end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives timestamps into the epoch-seconds to calendar converter: edge dates
// first, then random counts weighted toward month, leap-day and year
// boundaries, with random gaps on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int RANDOM_REQUESTS = 800;
    localparam int HOLD_AT_REQUEST = 200;
    localparam int HOLD_CYCLES     = 600;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_unix_seconds = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [4:0]  m_day_of_month;
    logic [3:0]  m_month_number;
    logic [11:0] m_year;
    logic [4:0]  m_hour;
    logic [5:0]  m_minute;
    logic [5:0]  m_second_of_minute;

    int mismatches;
    int outstanding;
    int conversions;
    int sent_count = 0;
    bit calm_window = 1'b0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    unix_time_to_calendar uut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_unix_seconds     (s_unix_seconds),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_day_of_month     (m_day_of_month),
        .m_month_number     (m_month_number),
        .m_year             (m_year),
        .m_hour             (m_hour),
        .m_minute           (m_minute),
        .m_second_of_minute (m_second_of_minute)
    );

    calendar_checker checker_i (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_unix_seconds     (s_unix_seconds),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_day_of_month     (m_day_of_month),
        .m_month_number     (m_month_number),
        .m_year             (m_year),
        .m_hour             (m_hour),
        .m_minute           (m_minute),
        .m_second_of_minute (m_second_of_minute),
        .mismatches         (mismatches),
        .outstanding        (outstanding),
        .conversions        (conversions)
    );

    // seconds since the epoch for a calendar date, wrapping at 32 bits
    function automatic logic [31:0] epoch_seconds(input int unsigned y,
                                                  input int unsigned m,
                                                  input int unsigned d,
                                                  input int unsigned hh,
                                                  input int unsigned mm,
                                                  input int unsigned ss);
        int unsigned first_day[12];
        int unsigned days;
        bit          leap;
        first_day = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
        days = 0;
        for (int unsigned k = 1970; k < y; k++)
            days += ((k % 4 == 0 && k % 100 != 0) || k % 400 == 0) ? 366 : 365;
        leap = (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
        days += first_day[m - 1] + d - 1 + ((leap && m > 2) ? 1 : 0);
        return 32'(days * 86400 + hh * 3600 + mm * 60 + ss);
    endfunction

    task automatic send_request(input logic [31:0] secs);
        while (!calm_window && $urandom_range(99) < 19) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_unix_seconds <= secs;
        do @(posedge aclk); while (!s_ready);
        sent_count++;
        @(negedge aclk);
    endtask

    // result side: random back-pressure plus one long hold-off
    initial begin : result_side
        bit held_off;
        held_off = 1'b0;
        forever begin
            @(negedge aclk);
            if (!held_off && sent_count >= HOLD_AT_REQUEST) begin
                held_off = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                m_ready <= calm_window || ($urandom_range(99) >= 19);
            end
        end
    end

    initial begin : request_side
        logic [31:0] edge_dates[$];
        logic [31:0] secs;
        int unsigned pick;
        int unsigned y;
        int unsigned m;
        int          directed;

        edge_dates.push_back(32'd0);
        edge_dates.push_back(32'd59);
        edge_dates.push_back(32'd3599);
        edge_dates.push_back(32'd86399);
        edge_dates.push_back(32'd86400);
        edge_dates.push_back(32'hFFFF_FFFF);
        edge_dates.push_back(32'h8000_0000);
        edge_dates.push_back(32'h7FFF_FFFF);
        edge_dates.push_back(epoch_seconds(1970, 12, 31, 23, 59, 59));
        edge_dates.push_back(epoch_seconds(1972, 2, 28, 23, 59, 59));
        edge_dates.push_back(epoch_seconds(1972, 2, 29, 0, 0, 0));
        edge_dates.push_back(epoch_seconds(1972, 3, 1, 0, 0, 0));
        edge_dates.push_back(epoch_seconds(1972, 12, 31, 0, 0, 0));
        edge_dates.push_back(epoch_seconds(1972, 12, 31, 23, 59, 59));
        edge_dates.push_back(epoch_seconds(1973, 1, 1, 0, 0, 0));
        edge_dates.push_back(epoch_seconds(1999, 12, 31, 23, 59, 59));
        edge_dates.push_back(epoch_seconds(2000, 2, 29, 12, 30, 30));
        edge_dates.push_back(epoch_seconds(2000, 12, 31, 23, 59, 59));
        edge_dates.push_back(epoch_seconds(2100, 2, 28, 23, 59, 59));
        edge_dates.push_back(epoch_seconds(2100, 3, 1, 0, 0, 0));
        edge_dates.push_back(epoch_seconds(2104, 12, 31, 23, 59, 59));
        edge_dates.push_back(epoch_seconds(2106, 2, 7, 6, 28, 14));
        directed = edge_dates.size();

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (edge_dates[i])
            send_request(edge_dates[i]);

        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            // stretch with no gaps on either side
            calm_window = (i >= 350 && i < 500);
            pick = $urandom_range(99);
            if (pick < 40) begin
                secs = $urandom();
            end else if (pick < 75) begin
                // around the first of a month
                y = $urandom_range(1970, 2106);
                m = (y == 2106) ? $urandom_range(1, 2) : $urandom_range(1, 12);
                secs = epoch_seconds(y, m, 1, 0, 0, 0) + $urandom_range(0, 345600)
                       - 32'd172800;
            end else if (pick < 90) begin
                // last day of a year divisible by four
                y = 4 * $urandom_range(493, 526);
                secs = epoch_seconds(y + 1, 1, 1, 0, 0, 0) - $urandom_range(1, 86400);
            end else begin
                secs = 32'hFFFF_FFFF - $urandom_range(0, 2000000);
            end
            send_request(secs);
        end
        calm_window = 1'b0;
        s_valid <= 1'b0;

        wait (outstanding == 0);
        repeat (200) @(posedge aclk);

        $display("covered %0d edge dates and %0d random timestamps around month,",
                 directed, RANDOM_REQUESTS);
        $display("leap-day and year boundaries; %0d conversions checked, %0d mismatches",
                 conversions, mismatches);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #(20_000_000);
        $display("FAIL");
        $finish;
    end

endmodule

/* unix_time_to_calendar.f */
rtl/core/ut2cal_pkg.sv
rtl/core/ut2cal_dp.sv
rtl/core/ut2cal_ctrl.sv
rtl/core/unix_time_to_calendar.sv
test/calendar_checker.sv
test/tb_top.sv
